[rtl/rmth_pkg.sv]
// rmth_pkg: shared constants, types and codes for the running median block
// used by rmth_cell, rmth_chain and running_median_two_heap; no dependencies
package rmth_pkg;

	localparam int CAPACITY     = 256;
	localparam int SAMPLE_WIDTH = 32;
	localparam int MED_WIDTH    = SAMPLE_WIDTH + 1;
	localparam int COUNT_WIDTH  = $clog2(CAPACITY + 1);
	// one half may hold one entry more than its share until the rebalance step
	localparam int HEAP_DEPTH   = CAPACITY / 2 + 1;
	localparam int HCNT_WIDTH   = $clog2(HEAP_DEPTH + 1);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [MED_WIDTH-1:0]    median_t;
	typedef logic [COUNT_WIDTH-1:0]         count_t;
	typedef logic [HCNT_WIDTH-1:0]          hcnt_t;
	typedef logic [HCNT_WIDTH:0]            hcnt_ext_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP
	} op_t;

	typedef struct packed {
		op_t     op;
		sample_t value;
	} chain_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_REBAL,
		ST_REPORT
	} state_t;

	// true when a ranks ahead of b in the given order
	function automatic logic ranks_above(input sample_t a, input sample_t b,
			input logic is_max);
		ranks_above = is_max ? (a > b) : (a < b);
	endfunction

endpackage

[rtl/rmth_cell.sv]
// rmth_cell: one entry of a sorted chain, takes from its neighbours on push or pop
// depends on rmth_pkg
module rmth_cell import rmth_pkg::*; (
	input  logic       clk,
	input  logic       is_max,
	input  logic       head,
	input  chain_cmd_t cmd,
	input  sample_t    prev_value,
	input  logic       prev_valid,
	input  sample_t    next_value,
	input  logic       self_valid,
	output sample_t    value
);

	sample_t value_q;
	logic    before_self;
	logic    before_prev;

	// where the pushed value lands relative to this entry and the one ahead
	assign before_self = !self_valid || ranks_above(cmd.value, value_q, is_max);
	assign before_prev = !head && (!prev_valid || ranks_above(cmd.value, prev_value, is_max));

	// shift down on push, shift up on pop
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_PUSH: begin
				if (before_self) begin
					value_q <= before_prev ? prev_value : cmd.value;
				end
			end
			OP_POP: begin
				value_q <= next_value;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign value = value_q;

endmodule

[rtl/rmth_chain.sv]
// rmth_chain: row of rmth_cell entries kept in order, best entry at the head
// depends on rmth_pkg and rmth_cell
module rmth_chain import rmth_pkg::*; (
	input  logic       clk,
	input  logic       is_max,
	input  chain_cmd_t cmd,
	input  hcnt_t      count,
	output sample_t    top
);

	sample_t                 vals [HEAP_DEPTH];
	logic [HEAP_DEPTH-1:0]   valid;

	// occupancy follows from the fill count of the half
	always_comb begin
		for (int i = 0; i < HEAP_DEPTH; i++) begin
			valid[i] = count > hcnt_t'(i);
		end
	end

	// row of cells, each wired to its neighbours, with the ends tied off
	for (genvar g = 0; g < HEAP_DEPTH; g++) begin : g_cell
		sample_t prev_v;
		logic    prev_ok;
		sample_t next_v;
		if (g == 0) begin : g_head
			assign prev_v  = '0;
			assign prev_ok = 1'b1;
		end else begin : g_body
			assign prev_v  = vals[g-1];
			assign prev_ok = valid[g-1];
		end
		if (g == HEAP_DEPTH - 1) begin : g_tail
			assign next_v = '0;
		end else begin : g_inner
			assign next_v = vals[g+1];
		end
		rmth_cell u_cell (
			.clk        (clk),
			.is_max     (is_max),
			.head       (g == 0),
			.cmd        (cmd),
			.prev_value (prev_v),
			.prev_valid (prev_ok),
			.next_value (next_v),
			.self_valid (valid[g]),
			.value      (vals[g])
		);
	end

	assign top = vals[0];

endmodule

[rtl/running_median_two_heap.sv]
// running_median_two_heap: streaming median over two ordered halves of the samples
// depends on rmth_pkg and rmth_chain
//
// Usage: drive sample and raise start; the transaction is taken at a rising
// edge where start is high and busy is low. busy stays high while the item
// is processed. The lower half is a chain of cells kept in descending order,
// the upper half a chain kept in ascending order, so each half's best entry
// sits at a fixed head cell. The insert step pushes the sample into a chain,
// the rebalance step moves a head across if the halves are out of balance,
// and the report step forms the doubled median from the two heads.
// done pulses for one cycle, registered from the report state, carrying
// median_x2, sample_count and dropped. busy is low in that cycle, so the next
// start can be taken while done is high; no new item is accepted while the
// insert, rebalance and report steps run.
// When CAPACITY samples are held the sample is discarded and dropped is set.
// The receiver cannot stall: median_x2 and sample_count hold until the next
// report, and dropped until the next insert.
// Reset (arst_n low) empties both halves at once and returns to idle.
module running_median_two_heap import rmth_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  sample_t sample,
	output logic    busy,
	output logic    done,
	output median_t median_x2,
	output count_t  sample_count,
	output logic    dropped
);

	state_t     state_q, state_d;
	sample_t    sample_q;
	hcnt_t      lower_cnt_q, lower_cnt_d;
	hcnt_t      upper_cnt_q, upper_cnt_d;
	logic       drop_q, drop_d;
	logic       done_q;
	median_t    median_q, median_d;
	count_t     count_q;
	count_t     total;
	logic       full;
	sample_t    lower_top;
	sample_t    upper_top;
	chain_cmd_t lower_cmd;
	chain_cmd_t upper_cmd;
	logic       report;

	assign total = count_t'(lower_cnt_q) + count_t'(upper_cnt_q);
	assign full  = total >= count_t'(CAPACITY);

	// lower half, largest at the head
	rmth_chain u_lower (
		.clk   (clk),
		.is_max(1'b1),
		.cmd   (lower_cmd),
		.count (lower_cnt_q),
		.top   (lower_top)
	);

	// upper half, smallest at the head
	rmth_chain u_upper (
		.clk   (clk),
		.is_max(1'b0),
		.cmd   (upper_cmd),
		.count (upper_cnt_q),
		.top   (upper_top)
	);

	// sequencer: insert, rebalance, report
	always_comb begin
		state_d     = state_q;
		lower_cnt_d = lower_cnt_q;
		upper_cnt_d = upper_cnt_q;
		drop_d      = drop_q;
		lower_cmd   = '{op: OP_HOLD, value: sample_q};
		upper_cmd   = '{op: OP_HOLD, value: sample_q};
		report      = 1'b0;
		median_d    = median_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				drop_d = full;
				if (!full) begin
					if (lower_cnt_q == '0 || sample_q <= lower_top) begin
						lower_cmd.op = OP_PUSH;
						lower_cnt_d  = lower_cnt_q + hcnt_t'(1);
					end else begin
						upper_cmd.op = OP_PUSH;
						upper_cnt_d  = upper_cnt_q + hcnt_t'(1);
					end
				end
				state_d = ST_REBAL;
			end
			ST_REBAL: begin
				priority if (hcnt_ext_t'(lower_cnt_q) > hcnt_ext_t'(upper_cnt_q) + hcnt_ext_t'(1)) begin
					lower_cmd.op    = OP_POP;
					upper_cmd.op    = OP_PUSH;
					upper_cmd.value = lower_top;
					lower_cnt_d     = lower_cnt_q - hcnt_t'(1);
					upper_cnt_d     = upper_cnt_q + hcnt_t'(1);
				end else if (lower_cnt_q < upper_cnt_q) begin
					upper_cmd.op    = OP_POP;
					lower_cmd.op    = OP_PUSH;
					lower_cmd.value = upper_top;
					upper_cnt_d     = upper_cnt_q - hcnt_t'(1);
					lower_cnt_d     = lower_cnt_q + hcnt_t'(1);
				end else begin
					lower_cmd.op = OP_HOLD;
				end
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				report = 1'b1;
				priority if (lower_cnt_q == '0) begin
					median_d = '0;
				end else if (lower_cnt_q > upper_cnt_q) begin
					median_d = {lower_top, 1'b0};
				end else begin
					median_d = median_t'(lower_top) + median_t'(upper_top);
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lower_cnt_q <= '0;
			upper_cnt_q <= '0;
			done_q      <= 1'b0;
			drop_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			lower_cnt_q <= lower_cnt_d;
			upper_cnt_q <= upper_cnt_d;
			done_q      <= report;
			drop_q      <= drop_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			sample_q <= sample;
		end
		median_q <= median_d;
	end

	// output register holds the count that goes with the result
	always_ff @(posedge clk) begin
		if (report) begin
			count_q <= total;
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign done         = done_q;
	assign median_x2    = median_q;
	assign sample_count = count_q;
	assign dropped      = drop_q;

endmodule

[sim/tb_running_median_two_heap.sv]
// tb_running_median_two_heap: self-checking testbench for the running median block
// depends on rmth_pkg and running_median_two_heap; predicts each result from two
// sorted halves of the held samples and checks every done strobe against it

module tb_running_median_two_heap import rmth_pkg::*; ();

	localparam int IDLE_LIMIT    = 2000;
	localparam int RANDOM_ITEMS  = 636;
	localparam int QUIET_FIRST   = 250;
	localparam int QUIET_LAST    = 400;

	// one expected result transaction
	typedef struct {
		median_t median_x2;
		count_t  sample_count;
		logic    dropped;
	} median_result_t;

	// median predictor and store of expected results
	class median_scoreboard;
		longint         lower_half[$];  // ascending, top is the last entry
		longint         upper_half[$];  // ascending, top is the first entry
		median_result_t awaited[$];
		int             mismatches;
		int             checked;
		int             drops;

		// position that keeps an ascending queue sorted
		function int sorted_slot(longint q[$], longint v);
			int i;
			i = 0;
			while (i < q.size() && q[i] <= v)
				i++;
			return i;
		endfunction

		// accepted input transaction: update the halves and queue the expected result
		function void note_sample(sample_t s);
			longint         v;
			longint         med;
			median_result_t r;
			v = longint'(s);
			r.dropped = 1'b0;
			if (lower_half.size() + upper_half.size() >= CAPACITY) begin
				r.dropped = 1'b1;
			end else begin
				// ties with the lower top stay in the lower half
				if (lower_half.size() == 0 || v <= lower_half[$])
					lower_half.insert(sorted_slot(lower_half, v), v);
				else
					upper_half.insert(sorted_slot(upper_half, v), v);
				// lower half holds as many as the upper half, or one more
				if (lower_half.size() > upper_half.size() + 1)
					upper_half.push_front(lower_half.pop_back());
				else if (lower_half.size() < upper_half.size())
					lower_half.push_back(upper_half.pop_front());
			end
			if (lower_half.size() == 0)
				med = 0;
			else if (lower_half.size() > upper_half.size())
				med = 2 * lower_half[$];
			else
				med = lower_half[$] + upper_half[0];
			r.median_x2    = median_t'(med);
			r.sample_count = count_t'(lower_half.size() + upper_half.size());
			awaited.push_back(r);
		endfunction

		// result transaction: compare field by field with the oldest expectation
		function void check_result(median_t m, count_t c, logic d);
			median_result_t r;
			if (awaited.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected: median_x2 %0d count %0d dropped %0b",
					$time, m, c, d);
				return;
			end
			r = awaited.pop_front();
			checked++;
			if (r.dropped)
				drops++;
			if (m !== r.median_x2) begin
				mismatches++;
				$display("%0t: median_x2 expected %0d actual %0d", $time, r.median_x2, m);
			end
			if (c !== r.sample_count) begin
				mismatches++;
				$display("%0t: sample_count expected %0d actual %0d",
					$time, r.sample_count, c);
			end
			if (d !== r.dropped) begin
				mismatches++;
				$display("%0t: dropped expected %0b actual %0b", $time, r.dropped, d);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    start;
	sample_t sample;
	logic    busy;
	logic    done;
	median_t median_x2;
	count_t  sample_count;
	logic    dropped;

	median_scoreboard sb;
	int               sent;
	int               idle_cycles;

	running_median_two_heap dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.sample       (sample),
		.busy         (busy),
		.done         (done),
		.median_x2    (median_x2),
		.sample_count (sample_count),
		.dropped      (dropped)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// offer one sample at a falling edge, hold it until the transaction is taken
	task automatic send_sample(input sample_t s);
		start  = 1'b1;
		sample = s;
		do
			@(posedge clk);
		while (busy);
		sb.note_sample(s);
		sent++;
		@(negedge clk);
	endtask

	// sender gap of a few cycles
	task automatic pause_sender(input int cycles);
		start  = 1'b0;
		sample = sample_t'($urandom);
		repeat (cycles) @(negedge clk);
	endtask

	// random sample: mostly full range, some clustered for ties, some extremes
	function automatic sample_t pick_sample();
		sample_t s;
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: s = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
					1: s = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
					2: s = '0;
					default: s = '1;
				endcase
			end
			1, 2, 3: s = sample_t'(int'($urandom_range(16)) - 8);
			default: s = sample_t'($urandom);
		endcase
		return s;
	endfunction

	// result monitor and watchdog on transactions
	always @(posedge clk) begin
		if (done)
			sb.check_result(median_x2, sample_count, dropped);
		if ((start && !busy) || done)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// stimulus and verdict
	initial begin
		sample_t directed[$];
		sb          = new();
		sent        = 0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		sample      = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: both extremes of the median, ties with the lower top, bit patterns
		directed = '{
			{1'b1, {(SAMPLE_WIDTH-1){1'b0}}},
			{1'b0, {(SAMPLE_WIDTH-1){1'b1}}},
			{1'b0, {(SAMPLE_WIDTH-1){1'b1}}},
			sample_t'(0), sample_t'(-1), sample_t'(1),
			sample_t'(0), sample_t'(0), sample_t'(0),
			sample_t'(32'h5555_5555), sample_t'(32'hAAAA_AAAA),
			sample_t'(-2), sample_t'(2), sample_t'(0)
		};
		foreach (directed[i]) begin
			send_sample(directed[i]);
			if (i % 4 == 3)
				pause_sender($urandom_range(1, 3));
		end

		// random: fills the store, then runs on with every sample dropped
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			send_sample(pick_sample());
			if ((n < QUIET_FIRST || n > QUIET_LAST) && $urandom_range(99) < 38)
				pause_sender($urandom_range(1, 6));
		end
		start = 1'b0;

		// drain, then a few cycles for any stray result
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d samples sent, %0d results checked, %0d of them dropped on a full store",
			sent, sb.checked, sb.drops);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
rtl/rmth_pkg.sv
rtl/rmth_cell.sv
rtl/rmth_chain.sv
rtl/running_median_two_heap.sv
sim/tb_running_median_two_heap.sv
